### rtl/aph_pkg.sv
`default_nettype none
package aph_pkg;

    localparam int DEF_STAGES      = 6;
    localparam int DEF_SINE_DEPTH  = 256;

    localparam int UNITY     = 65536;
    localparam int FB_MAX    = 62259;
    localparam int SAMPLE_W  = 24;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int QUOT_W    = 21;
    localparam int DIVD_W    = 18;
    localparam int CFG_W     = 24;

    localparam logic [16:0] SIN_C1 = 17'd5210;
    localparam logic [16:0] SIN_C2 = 17'd42334;
    localparam logic [16:0] SIN_C3 = 17'd102944;

    typedef enum logic [1:0] {
        CFG_SWEEP_LOW  = 2'd0,
        CFG_SWEEP_HIGH = 2'd1,
        CFG_LFO_STEP   = 2'd2,
        CFG_FADE_STEP  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN0,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_SIN4,
        ST_D0,
        ST_D1,
        ST_INC,
        ST_DIV_WAIT,
        ST_LOOP1,
        ST_SA,
        ST_SB,
        ST_WET1,
        ST_MIX0,
        ST_MIX1
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] num;
        logic [DIVD_W-1:0] den;
    } div_req_t;

    // round half away from zero
    function automatic logic signed [ACC_W-1:0] round_shift(
        input logic signed [ACC_W-1:0] v,
        input int unsigned             sh
    );
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] half;
        logic [ACC_W-1:0] r;
        half = ACC_W'(1) << (sh - 1);
        mag  = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        r    = (mag + half) >> sh;
        return v[ACC_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(signed'(24'sh7fffff)))
            return 24'sh7fffff;
        else if (v < ACC_W'(signed'(-24'sh800000)))
            return -24'sh800000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(32767))
            return 16'sh7fff;
        else if (v < -ACC_W'(32768))
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [16:0] clamp_gain(input logic signed [18:0] g);
        if (g > 19'sd65536)
            return 17'd65536;
        else if (g < 19'sd0)
            return 17'd0;
        else
            return g[16:0];
    endfunction

endpackage
`default_nettype wire

### rtl/aph_div.sv
`default_nettype none
module aph_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire aph_pkg::div_req_t            req,
    output logic                              done,
    output logic [aph_pkg::QUOT_W-1:0]        quot
);
    import aph_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIVD_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    den_reg, den_next;
    logic [QUOT_W-1:0]    sh_reg, sh_next;
    logic                 done_reg, done_next;
    logic [DIVD_W+QUOT_W+1:0] dividend;
    logic [DIVD_W:0]      trial;

    // (num << 20) + den/2
    assign dividend = ((DIVD_W+QUOT_W+2)'(req.num) << 20) + (DIVD_W+QUOT_W+2)'(req.den >> 1);
    assign trial    = {rem_reg, sh_reg[QUOT_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        sh_next   = sh_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = DIVD_W'(dividend >> QUOT_W);
            sh_next   = dividend[QUOT_W-1:0];
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (trial >= (DIVD_W+1)'(den_reg))
            begin
                rem_next = DIVD_W'(trial - (DIVD_W+1)'(den_reg));
                sh_next  = {sh_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVD_W-1:0];
                sh_next  = {sh_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        sh_reg  <= sh_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule
`default_nettype wire

### rtl/aph_smem.sv
`default_nettype none
module aph_smem #(
    parameter int STAGES = aph_pkg::DEF_STAGES,
    parameter int ADDR_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              we,
    input  wire logic [ADDR_W-1:0]                 waddr,
    input  wire logic signed [aph_pkg::SAMPLE_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]                 raddr,
    output logic signed [aph_pkg::SAMPLE_W-1:0]    rdata
);
    import aph_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [STAGES];
    logic [STAGES-1:0]          valid_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
    end

    // untouched entries read as zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (we)
            valid_reg[waddr] <= 1'b1;
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/allpass_phaser_with_bypass_fade.sv
// allpass phaser with bypass crossfade, one audio word per input handshake
// input channel: in_valid / in_stall carry in_sample, lfo_rate, feedback_gain,
//   mix_depth and bypass_toggle; a word is taken when in_valid is high and
//   in_stall low
// output channel: out_valid / out_stall carry out_sample and bypassed, one
//   result word for every input word, in order
// one word is processed at a time, from the accepting edge to the result
//   register, by one shared multiplier stepping the sine polynomial, sweep,
//   mix and two products per allpass stage, and a radix-2 divider forming
//   the 21-bit coefficient
// input pacing: no new word is taken until the result register is loaded;
//   the next word can be taken in the cycle after that, while the last
//   result may still wait there
// a held out_stall keeps the result register full; the sequencer then waits
//   at its final step until the register is free
// reset: all filter state, lfo phase and gains return to zero / unity,
//   configuration registers to their defaults; no clearing pass is needed
// configuration: cfg_we, cfg_index, cfg_data; the user writes them only while idle, a rule the block leaves unchecked
`default_nettype none
module allpass_phaser_with_bypass_fade #(
    parameter int STAGES           = aph_pkg::DEF_STAGES,
    parameter int SINE_TABLE_DEPTH = aph_pkg::DEF_SINE_DEPTH
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [aph_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [15:0]        in_sample,
    input  wire logic [16:0]               lfo_rate,
    input  wire logic [15:0]               feedback_gain,
    input  wire logic [16:0]               mix_depth,
    input  wire logic                      bypass_toggle,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [15:0]             out_sample,
    output logic                           bypassed
);
    import aph_pkg::*;

    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [15:0] sweep_low_reg, sweep_high_reg;
    logic [23:0] lfo_step_reg;
    logic [16:0] fade_step_reg;

    logic [31:0] phase_reg;
    logic signed [SAMPLE_W-1:0] loop_reg;
    logic [16:0] wr_reg, dr_reg, wf_reg, df_reg;
    logic        byp_reg;

    logic signed [15:0] x_reg;
    logic [16:0] rate_reg, depth_reg;
    logic [15:0] fb_reg;
    logic [16:0] xv_reg, x2_reg, u_reg;
    logic [1:0]  quad_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SAMPLE_W-1:0] y_reg, xs_reg, wet_reg;
    logic [STG_W-1:0] stg_reg;

    logic        out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic        out_byp_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic        accept;
    logic        out_free;
    logic        last_stg;

    logic [IDX_W-1:0] idx;
    logic [17:0] tpos;
    logic [16:0] x_now;
    logic [16:0] x2_now;
    logic [16:0] p1, p2, p_raw, p_cl;
    logic [16:0] u_now;
    logic [15:0] d_now;
    logic signed [22:0] dry;
    logic signed [ACC_W-1:0] dry_w, prod_w, sum_w;
    logic signed [SAMPLE_W-1:0] y_loop, y_stage, z_new, wet_now;
    logic signed [SAMPLE_W-1:0] z_rd;
    logic [16:0] g_dry, g_wet;

    logic byp_n;
    logic [16:0] wr_t, dr_t, wf_t, df_t;

    div_req_t         div_req;
    logic             div_done;
    logic [QUOT_W-1:0] coef_a;

    logic             mem_we;
    logic [STG_W-1:0] mem_raddr;

    aph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (coef_a)
    );

    aph_smem #(
        .STAGES (STAGES),
        .ADDR_W (STG_W)
    ) u_smem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (stg_reg),
        .wdata (z_new),
        .raddr (mem_raddr),
        .rdata (z_rd)
    );

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !(out_valid_reg && out_stall);
    assign last_stg = (stg_reg == STG_W'(STAGES - 1));

    // sine lookup point from the phase before the increment
    assign idx    = phase_reg[31 -: IDX_W];
    assign tpos   = 18'(idx) << (18 - IDX_W);
    assign x_now  = tpos[16] ? 17'(17'd65536 - 17'(tpos[15:0])) : 17'(tpos[15:0]);
    assign x2_now = prod_reg[32:16];
    assign p1     = SIN_C2 - prod_reg[32:16];
    assign p2     = SIN_C3 - prod_reg[32:16];
    assign p_raw  = prod_reg[32:16];
    assign p_cl   = (p_raw > 17'd65536) ? 17'd65536 : p_raw;
    assign u_now  = quad_reg[1] ? 17'((18'd65536 - 18'(p_cl)) >> 1)
                                : 17'((18'd65536 + 18'(p_cl)) >> 1);

    assign prod_w = ACC_W'(prod_reg);
    assign sum_w  = acc_reg + prod_w;
    assign d_now  = sum_w[31:16];

    assign dry     = 23'(x_reg) <<< 7;
    assign dry_w   = ACC_W'(dry);
    assign y_loop  = sat24(dry_w + round_shift(prod_w, 16));
    assign y_stage = sat24(ACC_W'(z_rd) - round_shift(prod_w, 20));
    assign z_new   = sat24(round_shift(prod_w, 20) + ACC_W'(xs_reg));
    assign wet_now = sat24(dry_w + round_shift(prod_w, 16));

    assign g_dry = byp_reg ? dr_reg : df_reg;
    assign g_wet = byp_reg ? wf_reg : wr_reg;

    // toggle then ramp step, applied at acceptance
    always_comb
    begin
        byp_n = byp_reg ^ bypass_toggle;
        wr_t  = bypass_toggle ? 17'd0 : wr_reg;
        dr_t  = bypass_toggle ? 17'd0 : dr_reg;
        wf_t  = bypass_toggle ? 17'd65536 : wf_reg;
        df_t  = bypass_toggle ? 17'd65536 : df_reg;
        if (byp_n)
        begin
            dr_t = clamp_gain(19'(dr_t) + 19'(fade_step_reg));
            wf_t = clamp_gain(19'(wf_t) - 19'(fade_step_reg));
        end
        else
        begin
            wr_t = clamp_gain(19'(wr_t) + 19'(fade_step_reg));
            df_t = clamp_gain(19'(df_t) - 19'(fade_step_reg));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_SIN0;
            ST_SIN0:     state_next = ST_SIN1;
            ST_SIN1:     state_next = ST_SIN2;
            ST_SIN2:     state_next = ST_SIN3;
            ST_SIN3:     state_next = ST_SIN4;
            ST_SIN4:     state_next = ST_D0;
            ST_D0:       state_next = ST_D1;
            ST_D1:       state_next = ST_INC;
            ST_INC:      state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_LOOP1;
            ST_LOOP1:    state_next = ST_SA;
            ST_SA:       state_next = ST_SB;
            ST_SB:       state_next = last_stg ? ST_WET1 : ST_SA;
            ST_WET1:     state_next = ST_MIX0;
            ST_MIX0:     state_next = ST_MIX1;
            ST_MIX1:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // multiplier operands, memory and divider control
    always_comb
    begin
        mul_a         = '0;
        mul_b         = '0;
        mem_we        = 1'b0;
        mem_raddr     = '0;
        div_req.start = 1'b0;
        div_req.num   = DIVD_W'(18'd65536 - 18'(d_now));
        div_req.den   = DIVD_W'(18'd65536 + 18'(d_now));
        unique case (state_reg)
            ST_SIN0:
            begin
                mul_a = MUL_W'(x_now);
                mul_b = MUL_W'(x_now);
            end
            ST_SIN1:
            begin
                mul_a = MUL_W'(SIN_C1);
                mul_b = MUL_W'(x2_now);
            end
            ST_SIN2:
            begin
                mul_a = MUL_W'(p1);
                mul_b = MUL_W'(x2_reg);
            end
            ST_SIN3:
            begin
                mul_a = MUL_W'(p2);
                mul_b = MUL_W'(xv_reg);
            end
            ST_SIN4:
            begin
                mul_a = MUL_W'(sweep_low_reg);
                mul_b = MUL_W'(17'd65536 - u_now);
            end
            ST_D0:
            begin
                mul_a = MUL_W'(sweep_high_reg);
                mul_b = MUL_W'(u_reg);
            end
            ST_D1:
            begin
                mul_a         = MUL_W'(lfo_step_reg);
                mul_b         = MUL_W'(rate_reg);
                div_req.start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                mul_a = MUL_W'(loop_reg);
                mul_b = MUL_W'(fb_reg);
            end
            ST_LOOP1:
            begin
                mul_a = MUL_W'(coef_a);
                mul_b = MUL_W'(y_loop);
            end
            ST_SA:
            begin
                mul_a = MUL_W'(coef_a);
                mul_b = MUL_W'(y_stage);
            end
            ST_SB:
            begin
                mem_we = 1'b1;
                if (last_stg)
                begin
                    mul_a = MUL_W'(y_reg);
                    mul_b = MUL_W'(depth_reg);
                end
                else
                begin
                    mul_a     = MUL_W'(coef_a);
                    mul_b     = MUL_W'(y_reg);
                    mem_raddr = stg_reg + STG_W'(1);
                end
            end
            ST_WET1:
            begin
                mul_a = MUL_W'(dry);
                mul_b = MUL_W'(g_dry);
            end
            ST_MIX0, ST_MIX1:
            begin
                mul_a = MUL_W'(wet_reg);
                mul_b = MUL_W'(g_wet);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sweep_low_reg  <= 16'd1308;
            sweep_high_reg <= 16'd4755;
            lfo_step_reg   <= 24'd97392;
            fade_step_reg  <= 17'd66;
            phase_reg      <= '0;
            loop_reg       <= '0;
            wr_reg         <= '0;
            dr_reg         <= '0;
            wf_reg         <= 17'd65536;
            df_reg         <= 17'd65536;
            byp_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            stg_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SWEEP_LOW:  sweep_low_reg  <= cfg_data[15:0];
                    CFG_SWEEP_HIGH: sweep_high_reg <= cfg_data[15:0];
                    CFG_LFO_STEP:   lfo_step_reg   <= cfg_data[23:0];
                    CFG_FADE_STEP:  fade_step_reg  <= cfg_data[16:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                byp_reg <= byp_n;
                wr_reg  <= wr_t;
                dr_reg  <= dr_t;
                wf_reg  <= wf_t;
                df_reg  <= df_t;
            end
            if (state_reg == ST_INC)
                phase_reg <= phase_reg + prod_reg[47:16];
            if (state_reg == ST_LOOP1)
                stg_reg <= '0;
            else if (state_reg == ST_SB && !last_stg)
                stg_reg <= stg_reg + STG_W'(1);
            if (state_reg == ST_SB && last_stg)
                loop_reg <= y_reg;
            if (state_reg == ST_MIX1 && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            x_reg     <= in_sample;
            rate_reg  <= (lfo_rate > 17'd65536) ? 17'd65536 : lfo_rate;
            fb_reg    <= (feedback_gain > 16'(FB_MAX)) ? 16'(FB_MAX) : feedback_gain;
            depth_reg <= (mix_depth > 17'd65536) ? 17'd65536 : mix_depth;
        end
        if (state_reg == ST_SIN0)
        begin
            xv_reg   <= x_now;
            quad_reg <= tpos[17:16];
        end
        if (state_reg == ST_SIN1)
            x2_reg <= x2_now;
        if (state_reg == ST_SIN4)
            u_reg <= u_now;
        if (state_reg == ST_D0 || state_reg == ST_MIX0)
            acc_reg <= prod_w;
        if (state_reg == ST_LOOP1)
            xs_reg <= y_loop;
        if (state_reg == ST_SA)
            y_reg <= y_stage;
        if (state_reg == ST_SB)
            xs_reg <= y_reg;
        if (state_reg == ST_WET1)
            wet_reg <= wet_now;
        if (state_reg == ST_MIX1 && out_free)
        begin
            out_sample_reg <= sat16(round_shift(sum_w, 23));
            out_byp_reg    <= byp_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign bypassed   = out_byp_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SIN0)
        else $error("accepted word did not start the sequencer");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("coefficient finished outside its wait step");

    a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MIX1))
        else $error("result word raised outside the final mix step");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> stg_reg <= STG_W'(STAGES - 1))
        else $error("stage write beyond the chain");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(out_sample_reg))
        else $error("waiting result word overwritten");

endmodule
`default_nettype wire

### verif/tb_allpass_phaser_with_bypass_fade.sv
`timescale 1ns / 100ps
module tb_allpass_phaser_with_bypass_fade;
    import aph_pkg::*;

    localparam int N_STAGES = 6;
    localparam int LATENCY = 60;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic signed [15:0] sample;
        logic               bypass;
    } phaser_word_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [16:0]        rate;
        logic [15:0]        fb;
        logic [16:0]        depth;
        logic               toggle;
        logic               typed;
        logic signed [15:0] out_typed;
        logic               byp_typed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] in_sample;
    logic [16:0] lfo_rate;
    logic [15:0] feedback_gain;
    logic [16:0] mix_depth;
    logic bypass_toggle;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] out_sample;
    logic bypassed;

    allpass_phaser_with_bypass_fade u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_sample(in_sample),
        .lfo_rate(lfo_rate),
        .feedback_gain(feedback_gain),
        .mix_depth(mix_depth),
        .bypass_toggle(bypass_toggle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_sample(out_sample),
        .bypassed(bypassed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    longint sweep_lo, sweep_hi, lfo_inc_full, ramp_step;
    logic [31:0] lfo_acc;
    longint fb_mem;
    longint allpass_mem [N_STAGES];
    longint wet_up, dry_up, wet_down, dry_down;
    logic bypass_on;

    phaser_word_t pending_words[$];
    int errors = 0;
    int accepts = 0;
    logic quiet = 1'b0;
    logic hold_req = 1'b0;

    function automatic longint rnd_shift(longint v, int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint clip_gain(longint g);
        if (g > UNITY)
            return UNITY;
        if (g < 0)
            return 0;
        return g;
    endfunction

    function automatic longint sine_lookup(logic [7:0] idx);
        longint t, quad, f, x, x2, p;
        t = longint'(idx) * 1024;
        quad = (t >> 16) & 3;
        f = t & 16'hffff;
        x = (quad & 1) ? (65536 - f) : f;
        x2 = (x * x) >> 16;
        p = 42334 - ((5210 * x2) >> 16);
        p = 102944 - ((p * x2) >> 16);
        p = (p * x) >> 16;
        if (p > UNITY)
            p = UNITY;
        return (quad & 2) ? -p : p;
    endfunction

    function automatic phaser_word_t phaser_predict(logic signed [15:0] smp, logic [16:0] rate_in,
                                                    logic [15:0] fb_in, logic [16:0] depth_in,
                                                    logic tog);
        phaser_word_t r;
        longint rate, fb, depth, u, d, num, den, a, dry, wet, y, xs, mix;
        rate = (rate_in > UNITY) ? UNITY : rate_in;
        fb = (fb_in > FB_MAX) ? FB_MAX : fb_in;
        depth = (depth_in > UNITY) ? UNITY : depth_in;
        if (tog)
        begin
            bypass_on = !bypass_on;
            wet_up = 0;
            dry_up = 0;
            wet_down = UNITY;
            dry_down = UNITY;
        end
        u = (sine_lookup(lfo_acc[31:24]) + UNITY) >> 1;
        d = (sweep_lo * (UNITY - u) + sweep_hi * u) >> 16;
        lfo_acc = lfo_acc + 32'((lfo_inc_full * rate) >> 16);
        num = UNITY - d;
        den = UNITY + d;
        a = ((num << 20) + den / 2) / den;
        dry = longint'(smp) * 128;
        y = clip24(dry + rnd_shift(fb_mem * fb, 16));
        for (int i = 0; i < N_STAGES; i++)
        begin
            xs = y;
            y = clip24(allpass_mem[i] - rnd_shift(a * xs, 20));
            allpass_mem[i] = clip24(rnd_shift(a * y, 20) + xs);
        end
        fb_mem = y;
        wet = clip24(dry + rnd_shift(y * depth, 16));
        if (bypass_on)
        begin
            dry_up = clip_gain(dry_up + ramp_step);
            wet_down = clip_gain(wet_down - ramp_step);
            mix = dry * dry_up + wet * wet_down;
        end
        else
        begin
            wet_up = clip_gain(wet_up + ramp_step);
            dry_down = clip_gain(dry_down - ramp_step);
            mix = dry * dry_down + wet * wet_up;
        end
        mix = rnd_shift(mix, 23);
        if (mix > 32767)
            mix = 32767;
        if (mix < -32768)
            mix = -32768;
        r.sample = 16'(mix);
        r.bypass = bypass_on;
        return r;
    endfunction

    task automatic write_regs(longint lo, longint hi, longint inc, longint stp);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SWEEP_LOW;
        cfg_data <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= CFG_SWEEP_HIGH;
        cfg_data <= CFG_W'(hi);
        @(posedge clk);
        cfg_index <= CFG_LFO_STEP;
        cfg_data <= CFG_W'(inc);
        @(posedge clk);
        cfg_index <= CFG_FADE_STEP;
        cfg_data <= CFG_W'(stp);
        @(posedge clk);
        cfg_we <= 1'b0;
        sweep_lo = lo & 16'hffff;
        sweep_hi = hi & 16'hffff;
        lfo_inc_full = inc & 24'hffffff;
        ramp_step = stp & 17'h1ffff;
    endtask

    // drives one word and waits for it to be taken, returns at the accepting edge
    task automatic send_word(stim_row_t w);
        phaser_word_t p;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_sample <= w.sample;
        lfo_rate <= w.rate;
        feedback_gain <= w.fb;
        mix_depth <= w.depth;
        bypass_toggle <= w.toggle;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = phaser_predict(w.sample, w.rate, w.fb, w.depth, w.toggle);
        if (w.typed)
        begin
            p.sample = w.out_typed;
            p.bypass = w.byp_typed;
        end
        pending_words.push_back(p);
    endtask

    task automatic drain;
        @(posedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic stim_row_t random_word();
        stim_row_t w;
        w.sample = 16'($urandom);
        w.rate = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, UNITY));
        w.fb = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, FB_MAX));
        w.depth = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, UNITY));
        w.toggle = ($urandom_range(0, 39) == 0);
        w.typed = 1'b0;
        w.out_typed = '0;
        w.byp_typed = 1'b0;
        return w;
    endfunction

    stim_row_t directed [16] = '{
        '{16'sd0,      17'd0,      16'd0,     17'd0,      1'b0, 1'b1, 16'sd0, 1'b0},
        '{16'sd0,      17'd65536,  16'd62259, 17'd65536,  1'b0, 1'b1, 16'sd0, 1'b0},
        '{16'sd0,      17'd0,      16'd0,     17'd0,      1'b1, 1'b1, 16'sd0, 1'b1},
        '{16'sd0,      17'd0,      16'd0,     17'd0,      1'b1, 1'b1, 16'sd0, 1'b0},
        '{16'sd32767,  17'd65536,  16'd62259, 17'd65536,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd32767,  17'd65536,  16'd62259, 17'd65536,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd32768, 17'd65536,  16'd62259, 17'd65536,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd32768, 17'd131071, 16'd65535, 17'd131071, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd32767,  17'd65537,  16'd62260, 17'd65537,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd1,      17'd0,      16'd0,     17'd0,      1'b1, 1'b0, 16'sd0, 1'b0},
        '{-16'sd1,     17'd32768,  16'd30000, 17'd32768,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd8192,   17'd65536,  16'd0,     17'd0,      1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd8192,  17'd1,      16'd1,     17'd1,      1'b1, 1'b0, 16'sd0, 1'b0},
        '{16'sd12345,  17'd99999,  16'd0,     17'd65536,  1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sd32768, 17'd0,      16'd62259, 17'd0,      1'b1, 1'b0, 16'sd0, 1'b0},
        '{16'sd32767,  17'd0,      16'd62259, 17'd65536,  1'b1, 1'b0, 16'sd0, 1'b0}
    };

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            accepts++;
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, actual sample %0d bypassed %0b",
                         $time, out_sample, bypassed);
            end
            else
            begin
                phaser_word_t e;
                e = pending_words.pop_front();
                if (out_sample !== e.sample)
                begin
                    errors++;
                    $display("%0t: out_sample expected %0d actual %0d", $time, e.sample, out_sample);
                end
                if (bypassed !== e.bypass)
                begin
                    errors++;
                    $display("%0t: bypassed expected %0b actual %0b", $time, e.bypass, bypassed);
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
            accepts++;
    end

    // receiver back-pressure
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(posedge clk);
            end
        end
    end

    // watchdog
    initial
    begin
        int idle_cycles;
        int last_accepts;
        idle_cycles = 0;
        last_accepts = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (accepts != last_accepts || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            last_accepts = accepts;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        longint phase_regs [5][4];
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SWEEP_LOW;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_sample <= '0;
        lfo_rate <= '0;
        feedback_gain <= '0;
        mix_depth <= '0;
        bypass_toggle <= 1'b0;
        sweep_lo = 1308;
        sweep_hi = 4755;
        lfo_inc_full = 97392;
        ramp_step = 66;
        lfo_acc = '0;
        fb_mem = 0;
        foreach (allpass_mem[i])
            allpass_mem[i] = 0;
        wet_up = 0;
        dry_up = 0;
        wet_down = UNITY;
        dry_down = UNITY;
        bypass_on = 1'b0;

        phase_regs[0] = '{0, 65535, 24'hffffff, 65536};
        phase_regs[1] = '{60000, 500, $urandom_range(0, 24'hffffff), 0};
        phase_regs[2] = '{65535, 65535, 0, 131071};
        phase_regs[3] = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 24'hffffff), $urandom_range(1, 4000)};
        phase_regs[4] = '{1308, 4755, 97392, 66};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_word(directed[i]);
        for (int n = 0; n < 280; n++)
            send_word(random_word());
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_word(random_word());

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_regs(phase_regs[ph][0], phase_regs[ph][1], phase_regs[ph][2], phase_regs[ph][3]);
            for (int n = 0; n < 270; n++)
            begin
                if (ph == 4 && n == 150)
                    quiet = 1'b1;
                if (ph == 2 && n == 100)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_words.size() != 0)
                        @(posedge clk);
                end
                send_word(random_word());
            end
        end

        @(posedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
